>>> rtl/lpe_pkg.sv
`default_nettype none

package lpe_pkg;

	// Level conversion: time / 61 for times below the limit, else full level
	localparam int unsigned TIME_LIMIT  = 15625 - 77;
	localparam int unsigned TIME_W      = 16;
	localparam int unsigned TIME_USED_W = 14;
	localparam int unsigned RECIP_SHIFT = 26;
	localparam int unsigned LEVEL_RECIP = (1 << RECIP_SHIFT) / 61 + 1;
	localparam int unsigned RECIP_W     = 21;
	localparam int unsigned PROD_W      = TIME_USED_W + RECIP_W;
	localparam int unsigned LEVEL_W     = 8;
	localparam logic [LEVEL_W-1:0] FULL_LEVEL = 8'd255;

	// Weights W(i) = 329 - 94*i
	localparam int WEIGHT_LEFT = 329;
	localparam int WEIGHT_STEP = 94;
	localparam int MID_OFFSET  = 47;

	localparam logic [2:0] NO_LINE_FIRST = 3'd3;
	localparam logic [2:0] NO_LINE_LAST  = 3'd4;

	localparam int unsigned THR_W = 11;
	localparam logic [THR_W-1:0] THRESHOLD_RESET = 11'd1000;

	// Divider: 15-bit magnitude numerator, 9-bit magnitude divisor
	localparam int unsigned NUM_W      = 15;
	localparam int unsigned DEN_W      = 9;
	localparam int unsigned DIV_BITS   = 3;
	localparam int unsigned DIV_STAGES = NUM_W / DIV_BITS;
	localparam int unsigned BASE_W     = 11;
	localparam int unsigned POS_W      = 16;

	typedef struct packed {
		logic [NUM_W-1:0]         nq;       // numerator shifting out, quotient shifting in
		logic [DEN_W-1:0]         den_mag;
		logic [DEN_W-1:0]         rem;
		logic                     neg;
		logic                     dz;
		logic                     single;
		logic signed [BASE_W-1:0] base;
		logic                     found;
		logic [2:0]               first;
		logic [2:0]               last;
	} div_word_t;

	// Position before interpolation: W(f) alone, or mean weight minus 47
	function automatic logic signed [BASE_W-1:0] base_of(
		input logic [2:0] first,
		input logic [2:0] last
	);
		int v;
		if (first == last) begin
			v = WEIGHT_LEFT - WEIGHT_STEP * int'(first);
		end else begin
			v = WEIGHT_LEFT - MID_OFFSET - MID_OFFSET * (int'(first) + int'(last));
		end
		return BASE_W'(v);
	endfunction

endpackage

`default_nettype wire

>>> rtl/lpe_front.sv
`default_nettype none

module lpe_front import lpe_pkg::*; (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               in_valid,
	output logic               in_stall,
	input  logic [7:0]         line_mask,
	input  logic [TIME_W-1:0]  time_2,
	input  logic [TIME_W-1:0]  time_3,
	input  logic [TIME_W-1:0]  time_4,
	input  logic [TIME_W-1:0]  time_5,
	input  logic [THR_W-1:0]   threshold,
	output logic               out_valid,
	output div_word_t          out_word,
	input  logic               down_ready
);

	logic               v_s1, v_s2, v_s3;
	logic               rdy_s1, rdy_s2, rdy_s3;

	logic [7:0]         mask_s1;
	logic [LEVEL_W-1:0] lvl_s1 [4];
	logic [2:0]         first_s1, last_s1;
	logic               found_s1;

	logic signed [8:0]  diff_s2;
	logic signed [9:0]  den_s2;
	logic signed [BASE_W-1:0] base_s2;
	logic               single_s2;
	logic               found_s2;
	logic [2:0]         first_s2, last_s2;

	div_word_t          word_s3;

	assign rdy_s3   = !v_s3 || down_ready;
	assign rdy_s2   = !v_s2 || rdy_s3;
	assign rdy_s1   = !v_s1 || rdy_s2;
	assign in_stall = !rdy_s1;

	// Stage 1: levels of the middle sensors, first and last set sensors
	logic [TIME_W-1:0]  tm [4];
	logic [PROD_W-1:0]  prod [4];
	logic [LEVEL_W-1:0] lvl_c [4];
	logic [2:0]         first_c, last_c;

	always_comb begin
		tm[0] = time_2;
		tm[1] = time_3;
		tm[2] = time_4;
		tm[3] = time_5;
		for (int k = 0; k < 4; k++) begin
			prod[k]  = PROD_W'(tm[k][TIME_USED_W-1:0]) * PROD_W'(LEVEL_RECIP);
			lvl_c[k] = (tm[k] < TIME_W'(TIME_LIMIT)) ? prod[k][RECIP_SHIFT +: LEVEL_W]
			                                          : FULL_LEVEL;
		end
	end

	always_comb begin
		first_c = NO_LINE_FIRST;
		last_c  = NO_LINE_LAST;
		for (int i = 7; i >= 0; i--) begin
			if (line_mask[i]) first_c = 3'(i);
		end
		for (int i = 0; i < 8; i++) begin
			if (line_mask[i]) last_c = 3'(i);
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1 <= 1'b0;
		end else if (rdy_s1) begin
			v_s1 <= in_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (rdy_s1 && in_valid) begin
			mask_s1  <= line_mask;
			lvl_s1   <= lvl_c;
			first_s1 <= first_c;
			last_s1  <= last_c;
			found_s1 <= |line_mask;
		end
	end

	// Stage 2: pick the end levels, offset them by the threshold terms
	logic [LEVEL_W-1:0] lvl_all [8];
	logic [LEVEL_W-1:0] lf, ll;

	always_comb begin
		for (int i = 0; i < 8; i++) begin
			lvl_all[i] = mask_s1[i] ? FULL_LEVEL : '0;
		end
		for (int k = 0; k < 4; k++) begin
			lvl_all[k + 2] = lvl_s1[k];
		end
		lf = lvl_all[first_s1];
		ll = lvl_all[last_s1];
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s2 <= 1'b0;
		end else if (rdy_s2) begin
			v_s2 <= v_s1;
		end
	end

	always_ff @(posedge clk) begin
		if (rdy_s2 && v_s1) begin
			diff_s2   <= $signed({1'b0, lf}) - $signed({1'b0, threshold[THR_W-1:3]});
			den_s2    <= $signed({2'b00, lf}) + $signed({2'b00, ll})
			           - $signed({1'b0, threshold[THR_W-1:2]});
			base_s2   <= base_of(first_s1, last_s1);
			single_s2 <= (first_s1 == last_s1);
			found_s2  <= found_s1;
			first_s2  <= first_s1;
			last_s2   <= last_s1;
		end
	end

	// Stage 3: scale the numerator, split signs from magnitudes
	logic signed [POS_W-1:0] num_c;
	logic [POS_W-1:0]        num_abs;
	logic [9:0]              den_abs;

	always_comb begin
		num_c   = $signed({{(POS_W-9){diff_s2[8]}}, diff_s2}) * POS_W'(WEIGHT_STEP);
		num_abs = num_c[POS_W-1] ? POS_W'(-num_c) : POS_W'(num_c);
		den_abs = den_s2[9] ? 10'(-den_s2) : 10'(den_s2);
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s3 <= 1'b0;
		end else if (rdy_s3) begin
			v_s3 <= v_s2;
		end
	end

	always_ff @(posedge clk) begin
		if (rdy_s3 && v_s2) begin
			word_s3.nq      <= num_abs[NUM_W-1:0];
			word_s3.den_mag <= den_abs[DEN_W-1:0];
			word_s3.rem     <= '0;
			word_s3.neg     <= num_c[POS_W-1] ^ den_s2[9];
			word_s3.dz      <= (den_s2 == '0) && !single_s2;
			word_s3.single  <= single_s2;
			word_s3.base    <= base_s2;
			word_s3.found   <= found_s2;
			word_s3.first   <= first_s2;
			word_s3.last    <= last_s2;
		end
	end

	assign out_valid = v_s3;
	assign out_word  = word_s3;

endmodule

`default_nettype wire

>>> rtl/lpe_div_stage.sv
`default_nettype none

module lpe_div_stage import lpe_pkg::*; (
	input  logic      clk,
	input  logic      arst_n,
	input  logic      in_valid,
	input  div_word_t in_word,
	output logic      in_ready,
	output logic      out_valid,
	output div_word_t out_word,
	input  logic      down_ready
);

	logic      v_s1;
	div_word_t word_s1;
	div_word_t nxt;
	logic [DEN_W:0] trial;

	assign in_ready = !v_s1 || down_ready;

	// Restoring division, a few quotient bits per stage
	always_comb begin
		nxt   = in_word;
		trial = '0;
		for (int b = 0; b < DIV_BITS; b++) begin
			trial  = {nxt.rem, nxt.nq[NUM_W-1]};
			nxt.nq = {nxt.nq[NUM_W-2:0], 1'b0};
			if (trial >= {1'b0, nxt.den_mag}) begin
				trial     = trial - {1'b0, nxt.den_mag};
				nxt.nq[0] = 1'b1;
			end
			nxt.rem = trial[DEN_W-1:0];
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1 <= 1'b0;
		end else if (in_ready) begin
			v_s1 <= in_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (in_ready && in_valid) begin
			word_s1 <= nxt;
		end
	end

	assign out_valid = v_s1;
	assign out_word  = word_s1;

endmodule

`default_nettype wire

>>> rtl/line_position_estimator.sv
`default_nettype none

// Line position estimator for an eight-sensor reflectance array. One frame
// (line mask and four middle-sensor capture times) enters per cycle while
// in_stall is low, and one result leaves per frame, in order. A frame passes
// the stages for level conversion and operand setup, five divider stages of
// three quotient bits each, and the output register. Throughput is one frame
// per clock while out_stall is low; the pipeline collapses bubbles, so input
// keeps flowing while a result waits on out_stall as long as a stage is empty.
// threshold_us resets to 1000 and is written through the cfg channel, which is
// always ready; write it only while no frame is in flight.

module line_position_estimator import lpe_pkg::*; (
	input  logic                    clk,
	input  logic                    arst_n,
	input  logic                    cfg_valid,
	output logic                    cfg_ready,
	input  logic [THR_W-1:0]        threshold_us,
	input  logic                    in_valid,
	output logic                    in_stall,
	input  logic [7:0]              line_mask,
	input  logic [TIME_W-1:0]       time_2,
	input  logic [TIME_W-1:0]       time_3,
	input  logic [TIME_W-1:0]       time_4,
	input  logic [TIME_W-1:0]       time_5,
	output logic                    out_valid,
	input  logic                    out_stall,
	output logic signed [POS_W-1:0] position_error,
	output logic                    line_found,
	output logic [2:0]              first_index,
	output logic [2:0]              last_index,
	output logic                    divide_by_zero
);

	logic [THR_W-1:0] threshold_q;

	assign cfg_ready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			threshold_q <= THRESHOLD_RESET;
		end else if (cfg_valid) begin
			threshold_q <= threshold_us;
		end
	end

	logic      dv    [DIV_STAGES+1];
	div_word_t dw    [DIV_STAGES+1];
	logic      drdy  [DIV_STAGES+1];
	logic      out_ready;

	lpe_front u_front (
		.clk        (clk),
		.arst_n     (arst_n),
		.in_valid   (in_valid),
		.in_stall   (in_stall),
		.line_mask  (line_mask),
		.time_2     (time_2),
		.time_3     (time_3),
		.time_4     (time_4),
		.time_5     (time_5),
		.threshold  (threshold_q),
		.out_valid  (dv[0]),
		.out_word   (dw[0]),
		.down_ready (drdy[0])
	);

	for (genvar g = 0; g < DIV_STAGES; g++) begin : g_div
		lpe_div_stage u_stage (
			.clk        (clk),
			.arst_n     (arst_n),
			.in_valid   (dv[g]),
			.in_word    (dw[g]),
			.in_ready   (drdy[g]),
			.out_valid  (dv[g+1]),
			.out_word   (dw[g+1]),
			.down_ready (drdy[g+1])
		);
	end

	assign out_ready            = !out_valid || !out_stall;
	assign drdy[DIV_STAGES]     = out_ready;

	// Apply the quotient sign, drop the term for one sensor or a zero divisor
	div_word_t               fin;
	logic signed [POS_W-1:0] q_c;
	logic signed [POS_W-1:0] pos_c;

	always_comb begin
		fin   = dw[DIV_STAGES];
		q_c   = fin.neg ? -$signed({1'b0, fin.nq}) : $signed({1'b0, fin.nq});
		pos_c = $signed({{(POS_W-BASE_W){fin.base[BASE_W-1]}}, fin.base});
		if (!fin.single && !fin.dz) begin
			pos_c = pos_c + q_c;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid <= 1'b0;
		end else if (out_ready) begin
			out_valid <= dv[DIV_STAGES];
		end
	end

	always_ff @(posedge clk) begin
		if (out_ready && dv[DIV_STAGES]) begin
			position_error <= pos_c;
			line_found     <= fin.found;
			first_index    <= fin.first;
			last_index     <= fin.last;
			divide_by_zero <= fin.dz;
		end
	end

endmodule

`default_nettype wire

>>> rtl/lpe_checker.sv
`default_nettype none

module lpe_checker (
	input logic              clk,
	input logic              arst_n,
	input logic              out_valid,
	input logic              out_stall,
	input logic signed [15:0] position_error,
	input logic              line_found,
	input logic [2:0]        first_index,
	input logic [2:0]        last_index,
	input logic              divide_by_zero
);

	// Hold a stalled result word
	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && out_stall |=> out_valid && $stable(position_error))
		else $error("result word dropped or changed under stall");

	a_order: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid |-> first_index <= last_index)
		else $error("first sensor past last sensor");

	a_no_line: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !line_found |-> first_index == 3'd3 && last_index == 3'd4)
		else $error("wrong default sensors when no line seen");

	a_single: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && first_index == last_index |->
			!divide_by_zero &&
			position_error == 16'sd329 - 16'sd94 * $signed({13'd0, first_index}))
		else $error("single sensor result is not its weight");

endmodule

bind line_position_estimator lpe_checker u_lpe_checker (
	.clk            (clk),
	.arst_n         (arst_n),
	.out_valid      (out_valid),
	.out_stall      (out_stall),
	.position_error (position_error),
	.line_found     (line_found),
	.first_index    (first_index),
	.last_index     (last_index),
	.divide_by_zero (divide_by_zero)
);

`default_nettype wire
